>>> rtl/psog_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psog_pkg
// Shared types and constants for the polar sweep order core.
// ----------------------------------------------------------------------------
package psog_pkg;

  localparam int ID_BITS = 11;

  typedef enum logic [1:0] {
    OP_PIVOT = 2'd0,
    OP_ADD   = 2'd1,
    OP_FETCH = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_WAIT,
    ST_INS_CMP,
    ST_INS_WR,
    ST_FS_RD,
    ST_FS_WAIT,
    ST_FS_INIT,
    ST_SC_RD,
    ST_SC_WAIT,
    ST_SC_CMP,
    ST_FE_RD,
    ST_FE_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic in_take;
    logic rd_prev;
    logic ins_cmp;
    logic ins_shift;
    logic ins_place;
    logic fs_first;
    logic fs_last;
    logic fs_init;
    logic sc_rd;
    logic sc_cmp;
    logic fe_rd;
    logic out_load;
  } psog_cmd_t;

  typedef struct packed {
    logic op_pivot;
    logic op_add;
    logic op_fetch;
    logic full;
    logic ins_done;
    logic key_gt;
    logic empty;
    logic sorted;
    logic wrap_equal;
    logic scan_done;
    logic pos_zero;
  } psog_sts_t;

endpackage

>>> rtl/psog_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psog_in_if / psog_out_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface psog_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic signed [15:0] x_coord;
  logic signed [15:0] y_coord;
  modport source (output valid, opcode, x_coord, y_coord, input ready);
  modport sink   (input valid, opcode, x_coord, y_coord, output ready);
endinterface

interface psog_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] point_id;
  logic [10:0] total_points;
  logic        last_flag;
  logic        status;
  modport source (output valid, point_id, total_points, last_flag, status, input ready);
  modport sink   (input valid, point_id, total_points, last_flag, status, output ready);
endinterface

>>> rtl/psog_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psog_ram
// Single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module psog_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/psog_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psog_ctrl
// Sequencer for insertion, start search and fetch.
// ----------------------------------------------------------------------------
module psog_ctrl import psog_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  psog_sts_t sts,
  output psog_cmd_t cmd
);
  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r && !out_ready;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_take = 1'b1;
          if (sts.op_add && !sts.full) begin
            state_nxt = ST_INS_RD;
          end else if (sts.op_fetch) begin
            state_nxt = sts.sorted ? ST_FE_RD : ST_FS_RD;
          end
        end
      end
      ST_INS_RD: begin
        if (sts.ins_done) begin
          state_nxt = ST_INS_WR;
        end else begin
          cmd.rd_prev = 1'b1;
          state_nxt   = ST_INS_WAIT;
        end
      end
      ST_INS_WAIT: state_nxt = ST_INS_CMP;
      ST_INS_CMP: begin
        cmd.ins_cmp = 1'b1;
        if (sts.key_gt) begin
          cmd.ins_shift = 1'b1;
          state_nxt     = ST_INS_RD;
        end else begin
          state_nxt = ST_INS_WR;
        end
      end
      ST_INS_WR: begin
        cmd.ins_place = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_FS_RD: begin
        if (sts.empty) begin
          cmd.fs_init = 1'b1;
          state_nxt   = ST_FE_RD;
        end else begin
          cmd.fs_first = 1'b1;
          state_nxt    = ST_FS_WAIT;
        end
      end
      ST_FS_WAIT: begin
        cmd.fs_last = 1'b1;
        state_nxt   = ST_FS_INIT;
      end
      ST_FS_INIT: begin
        cmd.fs_init = 1'b1;
        state_nxt   = sts.wrap_equal ? ST_FE_RD : ST_SC_RD;
      end
      ST_SC_RD: begin
        if (sts.scan_done) begin
          state_nxt = ST_FE_RD;
        end else begin
          cmd.sc_rd = 1'b1;
          state_nxt = ST_SC_WAIT;
        end
      end
      ST_SC_WAIT: state_nxt = ST_SC_CMP;
      ST_SC_CMP: begin
        cmd.sc_cmp = 1'b1;
        state_nxt  = ST_SC_RD;
      end
      ST_FE_RD: begin
        cmd.fe_rd = 1'b1;
        state_nxt = ST_FE_WAIT;
      end
      ST_FE_WAIT: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!ovalid_nxt) begin
          cmd.out_load = 1'b1;
          ovalid_nxt   = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(ovalid_r && !out_ready))
    else $error("result overwritten");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.in_take |-> state_r == ST_IDLE)
    else $error("take outside idle");
endmodule

>>> rtl/psog_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psog_dp
// Point store, exact angle comparators, gap search and fetch pointer.
// ----------------------------------------------------------------------------
module psog_dp import psog_pkg::*; #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            opcode,
  input  logic [COORD_BITS-1:0] x_coord,
  input  logic [COORD_BITS-1:0] y_coord,
  input  psog_cmd_t             cmd,
  output psog_sts_t             sts,
  output logic [ID_BITS-1:0]    point_id,
  output logic [ID_BITS-1:0]    total_points,
  output logic                  last_flag,
  output logic                  status
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int RW = COORD_BITS + 1;
  localparam int PW = 2 * RW + 1;
  localparam int GW = PW + 1;
  localparam int MW = GW + 1;

  function automatic logic half_f(input logic signed [GW-1:0] x, input logic signed [GW-1:0] y);
    half_f = !((y > 0) || (y == 0 && x > 0));
  endfunction

  logic signed [COORD_BITS-1:0] px_r, py_r;
  logic signed [RW-1:0] nx_r, ny_r;
  logic [CW-1:0] cnt_r, j_r, pos_r, si_r, idx_r;
  logic sorted_r, ovf_r;

  logic we;
  logic [AW-1:0] waddr, raddr, raddr_r;
  logic signed [RW-1:0] wx, wy, rx, ry;
  logic [ID_BITS-1:0] wid, rid;

  psog_ram #(.WIDTH(RW), .DEPTH(MAX_POINTS)) u_x (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wx), .raddr(raddr), .rdata(rx));
  psog_ram #(.WIDTH(RW), .DEPTH(MAX_POINTS)) u_y (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wy), .raddr(raddr), .rdata(ry));
  psog_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_POINTS)) u_id (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wid), .raddr(raddr), .rdata(rid));

  // direction of read entry
  logic signed [RW-1:0] dx, dy;
  always_comb begin
    dx = rx;
    dy = ry;
    if (rx == 0 && ry == 0) begin
      dy = -1;
    end
  end

  // insertion compare: stored key > new key
  logic signed [RW-1:0] ndx, ndy;
  logic signed [PW-1:0] c1, c2;
  logic ins_gt;
  logic [2*RW+1:0] da, db;
  always_comb begin
    ndx = nx_r;
    ndy = ny_r;
    if (nx_r == 0 && ny_r == 0) begin
      ndy = -1;
    end
    c1 = PW'(dx) * PW'(ndy);
    c2 = PW'(dy) * PW'(ndx);
    da = (2*RW+2)'(unsigned'(PW'(rx) * PW'(rx))) + (2*RW+2)'(unsigned'(PW'(ry) * PW'(ry)));
    db = (2*RW+2)'(unsigned'(PW'(nx_r) * PW'(nx_r)))
       + (2*RW+2)'(unsigned'(PW'(ny_r) * PW'(ny_r)));
    if (half_f(GW'(dx), GW'(dy)) != half_f(GW'(ndx), GW'(ndy))) begin
      ins_gt = half_f(GW'(dx), GW'(dy));
    end else if (c1 != c2) begin
      ins_gt = c1 < c2;
    end else begin
      ins_gt = da > db;
    end
  end

  // gap search: rotation vectors, compared in registered halves
  logic signed [RW-1:0] fx_r, fy_r;
  logic signed [GW-1:0] gx, gy, gx_r, gy_r, bx_r, by_r, wx0, wy0;
  logic signed [RW-1:0] prx_r, pry_r;
  logic signed [2*MW-1:0] m1, m2;
  logic gap_gt;
  always_comb begin
    gx = GW'(PW'(dx) * PW'(prx_r)) + GW'(PW'(dy) * PW'(pry_r));
    gy = GW'(PW'(dy) * PW'(prx_r)) - GW'(PW'(dx) * PW'(pry_r));
    wx0 = GW'(PW'(fx_r) * PW'(dx)) + GW'(PW'(fy_r) * PW'(dy));
    wy0 = GW'(PW'(fy_r) * PW'(dx)) - GW'(PW'(fx_r) * PW'(dy));
    m1 = (2*MW)'(gx_r) * (2*MW)'(by_r);
    m2 = (2*MW)'(gy_r) * (2*MW)'(bx_r);
    if (half_f(gx_r, gy_r) != half_f(bx_r, by_r)) begin
      gap_gt = half_f(gx_r, gy_r);
    end else begin
      gap_gt = m1 < m2;
    end
  end

  logic wrap_eq;
  assign wrap_eq = (half_f(GW'(dx), GW'(dy)) == half_f(GW'(fx_r), GW'(fy_r)))
                && (PW'(dx) * PW'(fy_r) == PW'(dy) * PW'(fx_r));

  // memory address and write
  logic [CW-1:0] fidx;
  always_comb begin
    fidx = CW'((CW+1)'(si_r) + (CW+1)'(pos_r) - (CW+1)'(1));
    if (fidx >= cnt_r) begin
      fidx = fidx - cnt_r;
    end
    raddr = raddr_r;
    if (cmd.rd_prev) raddr = AW'(j_r - 1'b1);
    if (cmd.fs_first) raddr = '0;
    if (cmd.fs_last) raddr = AW'(cnt_r - 1'b1);
    if (cmd.sc_rd) raddr = AW'(idx_r);
    if (cmd.fe_rd) raddr = AW'(fidx);
    we    = cmd.ins_shift || cmd.ins_place;
    waddr = AW'(j_r);
    wx    = cmd.ins_shift ? rx : nx_r;
    wy    = cmd.ins_shift ? ry : ny_r;
    wid   = cmd.ins_shift ? rid : ID_BITS'(cnt_r + CW'(2));
  end

  logic [CW-1:0] posf;
  assign posf = (pos_r > cnt_r) ? '0 : pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0; py_r <= '0; cnt_r <= '0; si_r <= '0; pos_r <= '0;
      sorted_r <= 1'b0; ovf_r <= 1'b0; raddr_r <= '0;
    end else begin
      raddr_r <= raddr;
      gx_r    <= gx;
      gy_r    <= gy;
      if (cmd.in_take) begin
        nx_r <= RW'(signed'(x_coord)) - RW'(px_r);
        ny_r <= RW'(signed'(y_coord)) - RW'(py_r);
        j_r  <= cnt_r;
        case (opcode_t'(opcode))
          OP_PIVOT: begin
            px_r <= x_coord; py_r <= y_coord; cnt_r <= '0; si_r <= '0;
            pos_r <= '0; sorted_r <= 1'b0; ovf_r <= 1'b0;
          end
          OP_ADD: begin
            sorted_r <= 1'b0; pos_r <= '0;
            if (cnt_r >= CW'(MAX_POINTS)) ovf_r <= 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd.ins_shift) j_r <= j_r - 1'b1;
      if (cmd.ins_place) cnt_r <= cnt_r + 1'b1;
      if (cmd.fs_last) begin
        fx_r <= dx; fy_r <= dy;
      end
      if (cmd.fs_init) begin
        prx_r <= fx_r; pry_r <= fy_r;
        bx_r <= wx0; by_r <= wy0;
        si_r <= '0; idx_r <= CW'(1); sorted_r <= 1'b1;
      end
      if (cmd.sc_cmp) begin
        prx_r <= dx; pry_r <= dy;
        idx_r <= idx_r + 1'b1;
        if (gap_gt) begin
          bx_r <= gx_r; by_r <= gy_r; si_r <= idx_r;
        end
      end
      if (cmd.out_load) begin
        point_id     <= (posf == 0) ? ID_BITS'(1) : rid;
        total_points <= ID_BITS'(cnt_r + 1'b1);
        last_flag    <= (posf == cnt_r);
        status       <= ovf_r;
        pos_r        <= (posf == cnt_r) ? '0 : posf + 1'b1;
      end
    end
  end

  always_comb begin
    sts            = '0;
    sts.op_pivot   = opcode == OP_PIVOT;
    sts.op_add     = opcode == OP_ADD;
    sts.op_fetch   = opcode == OP_FETCH;
    sts.full       = cnt_r >= CW'(MAX_POINTS);
    sts.ins_done   = (j_r == 0);
    sts.key_gt     = ins_gt;
    sts.empty      = cnt_r == 0;
    sts.sorted     = sorted_r;
    sts.wrap_equal = wrap_eq;
    sts.scan_done  = idx_r >= cnt_r;
    sts.pos_zero   = posf == 0;
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_POINTS)) else $error("count past capacity");
  a_jr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_shift |-> j_r != 0) else $error("shift below entry zero");
  a_si: assert property (@(posedge clk) disable iff (!rst_n)
    sorted_r && cnt_r != 0 |-> si_r < cnt_r) else $error("start index out of range");
endmodule

>>> rtl/polar_sweep_order_largest_gap_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_sweep_order_largest_gap_core
// Polar angle ordering around a pivot, starting after the largest gap.
// ----------------------------------------------------------------------------
//  channel | dir | transaction
//  in_*    | in  | opcode, x_coord, y_coord
//  out_*   | out | point_id, total_points, last_flag, status
// Every transaction is accepted in idle; pivot and no-op end there.
// An add then reads, waits and compares for each shifted entry, then writes the point.
// The first fetch after adds finds the start by reading the first and last points,
// then reading and comparing each later point unless all angles are equal, over one RAM port.
// A fetch then reads its entry and loads the result; a stalled result holds its register and the input.
// Reset is synchronous; stores need no clearing.
module polar_sweep_order_largest_gap_core import psog_pkg::*; #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16
) (
  input logic       clk,
  input logic       rst_n,
  psog_in_if.sink   in_ch,
  psog_out_if.source out_ch
);
  psog_cmd_t cmd;
  psog_sts_t sts;

  psog_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts(sts), .cmd(cmd));

  psog_dp #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .opcode(in_ch.opcode),
    .x_coord(COORD_BITS'(in_ch.x_coord)), .y_coord(COORD_BITS'(in_ch.y_coord)),
    .cmd(cmd), .sts(sts), .point_id(out_ch.point_id),
    .total_points(out_ch.total_points), .last_flag(out_ch.last_flag),
    .status(out_ch.status));
endmodule
